// File: hw/rtl/pral_pkg.sv
// Shared types and constants for the PID address range lookup block.
`default_nettype none

package pral_pkg;

  // Fixed field widths of the item ports.
  localparam int unsigned PID_W        = 16;
  localparam int unsigned FIELD_ADDR_W = 48;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned WIN_W        = 8;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Reset value of the close window register.
  localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd12;

  // Input item.
  typedef struct packed {
    logic                    operation;
    logic [PID_W-1:0]        proc_id;
    logic [FIELD_ADDR_W-1:0] address;
    logic [FIELD_ADDR_W-1:0] range_end;
    logic [TAG_W-1:0]        range_tag;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                    hit;
    logic [TAG_W-1:0]        found_tag;
    logic [FIELD_ADDR_W-1:0] offset;
    logic                    used_parent;
    logic                    table_full;
  } out_item_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic retry;
    logic check;
    logic write;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic is_lookup;
    logic retry_ok;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pral_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pral_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/pral_ctrl.sv
// Controller state machine that sequences table scans, writes and results.
`default_nettype none

module pral_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pral_pkg::ctrl_status_t status_i,
  output pral_pkg::ctrl_cmd_t        cmd_o
);

  import pral_pkg::*;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = status_i.is_lookup ? ST_CHECK : ST_WRITE;
        end
      end
      ST_CHECK: begin
        if (status_i.retry_ok) begin
          cmd_o.retry = 1'b1;
          state_d     = ST_SCAN;
        end else begin
          cmd_o.check = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pral_dp.sv
// Datapath: range table, scan logic, search registers and result register.
`default_nettype none

module pral_dp #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ADDR_BITS     = 48
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [7:0]              cfg_wdata_i,
  input  wire pral_pkg::in_item_t      in_item_i,
  input  wire pral_pkg::ctrl_cmd_t     cmd_i,
  output pral_pkg::ctrl_status_t       status_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output pral_pkg::out_item_t          out_item_o
);

  import pral_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENT_W = PID_W + 2 * ADDR_BITS + TAG_W;
  localparam int unsigned KEY_W = PID_W + ADDR_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // Control registers.
  logic [WIN_W-1:0] win_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rd_pend_q;
  logic             out_valid_q;

  // Item and search registers.
  logic                 op_q;
  logic [PID_W-1:0]     pid_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS-1:0] end_q;
  logic [TAG_W-1:0]     tag_q;
  logic [PID_W-1:0]     search_pid_q;
  logic [CNT_W-1:0]     idx_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 found_q;
  logic [PID_W-1:0]     best_pid_q;
  logic [ADDR_BITS-1:0] best_low_q;
  logic [ADDR_BITS-1:0] best_high_q;
  logic [TAG_W-1:0]     best_tag_q;
  logic                 match_q;
  logic [IDX_W-1:0]     match_idx_q;
  logic                 pass2_q;
  logic                 hit_q;
  logic                 full_q;
  out_item_t            out_q;

  // Table memory port signals.
  logic                 rd_en;
  logic [ENT_W-1:0]     rdata;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;

  // Fields of the entry read back during a scan.
  logic [PID_W-1:0]     e_pid;
  logic [ADDR_BITS-1:0] e_low;
  logic [ADDR_BITS-1:0] e_high;
  logic [TAG_W-1:0]     e_tag;
  logic [KEY_W-1:0]     e_key;
  logic [KEY_W-1:0]     s_key;
  logic [KEY_W-1:0]     b_key;
  logic                 take_best;
  logic                 take_match;
  logic [PID_W-1:0]     pid_diff;
  logic                 covers;
  logic                 has_room;
  logic [ADDR_BITS-1:0] offset;

  pral_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Scan reads one entry a cycle until the fill count is reached.
  assign rd_en = cmd_i.scan && (idx_q < count_q);

  assign e_pid  = rdata[ENT_W-1 -: PID_W];
  assign e_low  = rdata[2*ADDR_BITS+TAG_W-1 -: ADDR_BITS];
  assign e_high = rdata[ADDR_BITS+TAG_W-1 -: ADDR_BITS];
  assign e_tag  = rdata[TAG_W-1:0];
  assign e_key  = {e_pid, e_low};
  assign s_key  = {search_pid_q, addr_q};
  assign b_key  = {best_pid_q, best_low_q};

  // Predecessor tracking for lookups, exact key match for inserts.
  assign take_best  = rd_pend_q && (op_q == OP_LOOKUP) && (e_key <= s_key) &&
                      (!found_q || (e_key > b_key));
  assign take_match = rd_pend_q && (op_q == OP_INSERT) && !match_q && (e_key == s_key);

  // Retry decision and containment check on the best entry.
  assign pid_diff = pid_q - best_pid_q;
  assign covers   = found_q && (best_pid_q == search_pid_q) &&
                    (best_low_q <= addr_q) && (addr_q < best_high_q);
  assign offset   = addr_q - best_low_q;

  // Insert: overwrite a matching entry or append while there is room.
  assign has_room = (count_q < FULL_CNT);
  assign wr_en    = cmd_i.write && (match_q || has_room);
  assign wr_addr  = match_q ? match_idx_q : count_q[IDX_W-1:0];
  assign wr_data  = {pid_q, addr_q, end_q, tag_q};

  always_comb begin
    count_d = count_q;
    if (cmd_i.write && !match_q && has_room) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // Status to the controller.
  assign status_o.scan_done = (idx_q == count_q) && !rd_pend_q;
  assign status_o.is_lookup = (op_q == OP_LOOKUP);
  assign status_o.retry_ok  = !pass2_q && found_q && (best_pid_q != pid_q) &&
                              (pid_diff < PID_W'(win_q));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Control registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WINDOW_RESET;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      count_q   <= count_d;
      rd_pend_q <= rd_en;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, scan and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= in_item_i.operation;
      pid_q        <= in_item_i.proc_id;
      addr_q       <= in_item_i.address[ADDR_BITS-1:0];
      end_q        <= in_item_i.range_end[ADDR_BITS-1:0];
      tag_q        <= in_item_i.range_tag;
      search_pid_q <= in_item_i.proc_id;
      pass2_q      <= 1'b0;
    end else if (cmd_i.retry) begin
      search_pid_q <= best_pid_q;
      pass2_q      <= 1'b1;
    end

    if (cmd_i.load || cmd_i.retry) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (rd_en) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (take_best) begin
        found_q     <= 1'b1;
        best_pid_q  <= e_pid;
        best_low_q  <= e_low;
        best_high_q <= e_high;
        best_tag_q  <= e_tag;
      end
      if (take_match) begin
        match_q     <= 1'b1;
        match_idx_q <= rd_idx_q;
      end
    end

    if (rd_en) begin
      rd_idx_q <= idx_q[IDX_W-1:0];
    end
    if (cmd_i.check) begin
      hit_q <= covers;
    end
    if (cmd_i.write) begin
      full_q <= !(match_q || has_room);
    end

    if (cmd_i.finish) begin
      if (op_q == OP_LOOKUP) begin
        out_q.hit         <= hit_q;
        out_q.found_tag   <= hit_q ? best_tag_q : '0;
        out_q.offset      <= hit_q ? FIELD_ADDR_W'(offset) : '0;
        out_q.used_parent <= hit_q && pass2_q;
        out_q.table_full  <= 1'b0;
      end else begin
        out_q.hit         <= 1'b0;
        out_q.found_tag   <= '0;
        out_q.offset      <= '0;
        out_q.used_parent <= 1'b0;
        out_q.table_full  <= full_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/pid_address_range_lookup_unit.sv
// Top level of the PID address range lookup block.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  in_item_i  (pral_pkg::in_item_t)
//   out      output     out_valid_o/out_ready_i  out_item_o (pral_pkg::out_item_t)
//   cfg      input      cfg_we_i                 cfg_wdata_i (close window)
//
// One item is processed at a time. An item scans the table through the single
// read port of the table RAM, one entry a cycle; a lookup may scan the table a
// second time when the nearby-pid retry fires. After the result the controller
// returns to the idle state, where it accepts the next item. Reset clears the
// controller state, the fill count, the read-pending flag and the output valid
// flag, and sets the window register to its reset value; the table needs no
// clearing pass because only entries below the fill count are read. A stalled
// output holds its result while the next item is accepted and scanned; that
// item then waits in the finish state until the held result is taken.
`default_nettype none

module pid_address_range_lookup_unit #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ADDR_BITS     = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pral_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pral_pkg::out_item_t     out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  import pral_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  pral_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pral_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted on two consecutive cycles.");

  // A result never reports both a hit and a dropped insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.hit && out_item_o.table_full))
    else $error("Result reports hit and table full together.");

  // A miss carries no tag, offset or parent flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.hit |->
      out_item_o.found_tag == '0 && out_item_o.offset == '0 && !out_item_o.used_parent)
    else $error("Miss result carries hit data.");

  // The controller never finishes an item while the result register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> status.out_free)
    else $error("Result written while the output register was full.");

endmodule

`default_nettype wire
